@@ rtl/mbs_pkg.sv @@
// ============================================================================
// mbs_pkg
// Shared types and constants for the mask-row to span converter.
// ============================================================================
package mbs_pkg;

   localparam int COORD_W     = 16;   // coordinate and length width
   localparam int PIX_W       = 8;    // pixels per mask byte
   localparam int QUEUE_DEPTH = 4;    // entries between front and back
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] RIGHT_MASK_BASE = 16'hFF00;
   localparam logic [7:0]  LEFT_MASK_BASE  = 8'hFF;
   localparam logic [3:0]  KEEP_MAX        = 4'd8;

   typedef struct packed {
      logic [7:0]          mask_byte;
      logic                row_first;
      logic                row_last;
      logic signed [15:0]  row_x;
      logic signed [15:0]  row_y;
      logic [2:0]          left_skip;
      logic [3:0]          right_keep;
   } req_type;

   typedef struct packed {
      logic signed [15:0]  span_x;
      logic signed [15:0]  span_y;
      logic [15:0]         span_len;
      logic                last_span;
   } rsp_type;

   // one classified byte: run end/start positions plus the coordinates
   // needed to turn them into spans
   typedef struct packed {
      logic [PIX_W:0]         ends;     // bit PIX_W: row end closes a run
      logic [PIX_W-1:0]       starts;
      logic [COORD_W-1:0]     x0;
      logic [COORD_W-1:0]     y;
      logic [COORD_W-1:0]     sstart;   // start of a run carried in
   } entry_type;

endpackage

@@ rtl/mask_bits_to_spans_core.sv @@
// ============================================================================
// mask_bits_to_spans_core
// Converts a 1-bit-per-pixel mask row, byte by byte, into spans of set pixels.
// ============================================================================
//
//   channel   direction  handshake            payload
//   --------  ---------  -------------------  --------------------------------
//   request   in         push / full          req_data : mask byte, row info
//   response  out        empty / pop          rsp_data : span x, y, len, last
//
// One byte is taken per cycle while the queue has room; the front updates
// row state in the same cycle. The back emits one span per cycle unless a
// stalled pop holds the result register; a byte has at most five spans, and
// bytes with no span skip the queue. A four-entry queue decouples both sides.
// Reset is synchronous and empties queue, back stage and output register.
// A stalled pop holds the result register; full rises once the queue fills.
//
module mask_bits_to_spans_core import mbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   output logic     full,
   input  req_type  req_data,
   output logic     empty,
   input  logic     pop,
   output rsp_type  rsp_data
);

   logic       accept;
   logic       q_push, q_pop, q_empty;
   entry_type  q_entry, q_head;

   // take the byte whenever the queue has room
   assign accept = push & ~full;

   // front: mask, track row state, mark run edges
   mbs_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .req_data (req_data),
      .q_push   (q_push),
      .q_entry  (q_entry)
   );

   // queue between front and back
   mbs_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (q_push),
      .q_entry (q_entry),
      .q_full  (full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   // back: walk run ends, drive the result register
   mbs_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_empty  (q_empty),
      .q_head   (q_head),
      .q_pop    (q_pop),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

@@ rtl/mbs_front.sv @@
// ============================================================================
// mbs_front
// Accepts mask bytes, applies edge masks, tracks row state and marks run edges.
// ============================================================================
module mbs_front import mbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  req_type    req_data,
   output logic       q_push,
   output entry_type  q_entry
);

   logic                in_fill_ff, in_fill_in;
   logic [COORD_W-1:0]  span_start_ff, span_start_in;
   logic [COORD_W-1:0]  cur_x_ff, cur_x_in;
   logic [COORD_W-1:0]  cur_y_ff, cur_y_in;

   logic [COORD_W-1:0]  x0, y0;
   logic                fill0;
   logic [7:0]          bmask;
   logic [3:0]          keep;
   logic [7:0]          rmask;
   logic [PIX_W:0]      ends;
   logic [PIX_W-1:0]    starts;
   logic                prev;
   logic                pix;
   logic [3:0]          top_start;
   logic                any_start;

   always_comb begin
      x0    = req_data.row_first ? COORD_W'(req_data.row_x) : cur_x_ff;
      y0    = req_data.row_first ? COORD_W'(req_data.row_y) : cur_y_ff;
      fill0 = req_data.row_first ? 1'b0 : in_fill_ff;

      bmask = req_data.mask_byte;
      if (req_data.row_first) begin
         bmask = bmask & (LEFT_MASK_BASE >> req_data.left_skip);
      end
      keep  = (req_data.right_keep > KEEP_MAX) ? KEEP_MAX : req_data.right_keep;
      rmask = 8'(RIGHT_MASK_BASE >> keep);
      if (req_data.row_last) begin
         bmask = bmask & rmask;
      end

      // mark run starts and ends, leftmost pixel first
      prev   = fill0;
      starts = '0;
      ends   = '0;
      for (int i = 0; i < PIX_W; i++) begin
         pix       = bmask[PIX_W-1-i];
         starts[i] = pix & ~prev;
         ends[i]   = ~pix & prev;
         prev      = pix;
      end
      ends[PIX_W] = req_data.row_last & bmask[0];

      top_start = '0;
      any_start = 1'b0;
      for (int i = 0; i < PIX_W; i++) begin
         if (starts[i]) begin
            top_start = 4'(i);
            any_start = 1'b1;
         end
      end

      cur_x_in      = x0 + COORD_W'(PIX_W);
      cur_y_in      = y0;
      in_fill_in    = bmask[0] & ~req_data.row_last;
      span_start_in = span_start_ff;
      if (in_fill_in && any_start) begin
         span_start_in = x0 + COORD_W'(top_start);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_fill_ff    <= 1'b0;
         span_start_ff <= '0;
         cur_x_ff      <= '0;
         cur_y_ff      <= '0;
      end else if (accept) begin
         in_fill_ff    <= in_fill_in;
         span_start_ff <= span_start_in;
         cur_x_ff      <= cur_x_in;
         cur_y_ff      <= cur_y_in;
      end
   end

   // bytes without a run end produce nothing: keep them out of the queue
   assign q_push         = accept & (|ends);
   assign q_entry.ends   = ends;
   assign q_entry.starts = starts;
   assign q_entry.x0     = x0;
   assign q_entry.y      = y0;
   assign q_entry.sstart = span_start_ff;

endmodule

@@ rtl/mbs_queue.sv @@
// ============================================================================
// mbs_queue
// Short register queue of classified bytes between front and back.
// ============================================================================
module mbs_queue import mbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_push,
   input  entry_type  q_entry,
   output logic       q_full,
   input  logic       q_pop,
   output logic       q_empty,
   output entry_type  q_head
);

   entry_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QUEUE_AW:0]     count_ff, count_in;
   logic                  do_push, do_pop;

   assign q_full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push & ~q_full;
   assign do_pop  = q_pop & ~q_empty;

   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_entry;
      end
   end

endmodule

@@ rtl/mbs_back.sv @@
// ============================================================================
// mbs_back
// Walks one byte's run ends into an output register, one span per cycle unless stalled by pop.
// ============================================================================
module mbs_back import mbs_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       q_empty,
   input  entry_type  q_head,
   output logic       q_pop,
   output logic       empty,
   input  logic       pop,
   output rsp_type    rsp_data
);

   logic                cur_valid_ff;
   entry_type           cur_ff, cur_in;
   logic                out_valid_ff;
   rsp_type             out_ff, out_in;

   logic [3:0]          e_pos, s_pos;
   logic                s_found;
   logic [COORD_W-1:0]  start_x, end_x;
   logic [PIX_W:0]      ends_rem;
   logic [PIX_W-1:0]    starts_rem;
   logic                emit, done, load, taken;

   always_comb begin
      e_pos = '0;
      for (int i = PIX_W; i >= 0; i--) begin
         if (cur_ff.ends[i]) begin
            e_pos = 4'(i);
         end
      end
      s_pos   = '0;
      s_found = 1'b0;
      for (int i = PIX_W-1; i >= 0; i--) begin
         if (cur_ff.starts[i]) begin
            s_pos   = 4'(i);
            s_found = 1'b1;
         end
      end
      ends_rem   = cur_ff.ends;
      starts_rem = cur_ff.starts;
      for (int i = 0; i <= PIX_W; i++) begin
         if (4'(i) <= e_pos) begin
            ends_rem[i] = 1'b0;
         end
      end
      for (int i = 0; i < PIX_W; i++) begin
         if (4'(i) < e_pos) begin
            starts_rem[i] = 1'b0;
         end
      end
      start_x = (s_found && (s_pos < e_pos)) ? cur_ff.x0 + COORD_W'(s_pos) : cur_ff.sstart;
      end_x   = cur_ff.x0 + COORD_W'(e_pos);

      out_in.span_x    = start_x;
      out_in.span_y    = cur_ff.y;
      out_in.span_len  = end_x - start_x;
      out_in.last_span = ~(|ends_rem);

      cur_in        = cur_ff;
      cur_in.ends   = ends_rem;
      cur_in.starts = starts_rem;
   end

   assign taken = pop & out_valid_ff;
   assign emit  = cur_valid_ff & (~out_valid_ff | taken);
   assign done  = emit & out_in.last_span;
   assign load  = (~cur_valid_ff | done) & ~q_empty;
   assign q_pop = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            cur_valid_ff <= 1'b1;
         end else if (done) begin
            cur_valid_ff <= 1'b0;
         end
         if (emit) begin
            out_valid_ff <= 1'b1;
         end else if (taken) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         cur_ff <= q_head;
      end else if (emit) begin
         cur_ff <= cur_in;
      end
      if (emit) begin
         out_ff <= out_in;
      end
   end

   assign empty    = ~out_valid_ff;
   assign rsp_data = out_ff;

endmodule

@@ rtl/mbs_checker.sv @@
// ============================================================================
// mbs_checker
// Port-level checks on the span converter, bound to the top level.
// ============================================================================
module mbs_checker import mbs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  logic     full,
   input  req_type  req_data,
   input  logic     empty,
   input  logic     pop,
   input  rsp_type  rsp_data
);

   // reset leaves nothing waiting and room for input
   a_reset_clear: assert property (@(posedge clock)
      reset |=> (empty && !full))
      else $error("not empty or full after reset");

   // an offered item carries known bits
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      push |-> !$isunknown(req_data))
      else $error("offered item has unknown bits");

   // a span that is not the last of its item is followed at once by the next
   a_span_follow: assert property (@(posedge clock) disable iff (reset)
      (pop && !empty && !rsp_data.last_span) |=> !empty)
      else $error("gap inside the spans of one item");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting result changed");

endmodule

bind mask_bits_to_spans_core mbs_checker u_mbs_checker (
   .clock    (clock),
   .reset    (reset),
   .push     (push),
   .full     (full),
   .req_data (req_data),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);
